FILE: rtl/core/mrbr_pkg.sv
// ----------------------------------------------------------------------------
// Broadcast ring package
// Shared field widths, operation codes, result codes and item types of the
// single-writer, many-reader broadcast ring.
// ----------------------------------------------------------------------------
package mrbr_pkg;

    // Field widths fixed by the item format.
    localparam int OP_W    = 2;
    localparam int RID_W   = 3;
    localparam int DATA_W  = 64;
    localparam int SIZE_W  = 8;
    localparam int SLOT_W  = 10;
    localparam int QSIZE_W = 11;

    // Operation codes of an input item.
    localparam logic [OP_W-1:0] OP_WRITE    = 2'd0;
    localparam logic [OP_W-1:0] OP_REGISTER = 2'd1;
    localparam logic [OP_W-1:0] OP_READ     = 2'd2;

    // Result codes.
    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NO_DATA  = 2'd1,
        ST_UNKNOWN  = 2'd2,
        ST_NEW_DATA = 2'd3
    } t_status;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [RID_W-1:0]  reader_id;
        logic [DATA_W-1:0] entry_data;
        logic [SIZE_W-1:0] entry_size;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] entry_data_res;
        logic [SIZE_W-1:0] entry_size_res;
        logic [SLOT_W-1:0] slot_index;
        logic              more_data;
        logic              reader_known;
        logic              reader_started;
    } t_out_item;

    // One ring slot as held in the slot memory.
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [SIZE_W-1:0] size;
    } t_slot;

endpackage

FILE: rtl/core/mrbr_ifs.sv
// ----------------------------------------------------------------------------
// Broadcast ring channels
// Valid/ready channels for input items, result items and the ring size
// register write.
// ----------------------------------------------------------------------------

// Input item channel.
interface mrbr_in_if;
    import mrbr_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result item channel.
interface mrbr_out_if;
    import mrbr_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Ring size register write channel.
interface mrbr_cfg_if;
    import mrbr_pkg::*;
    logic               valid;
    logic               ready;
    logic [QSIZE_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/multi_reader_broadcast_ring.sv
// Latency: a result is valid in the cycle after its input item is transferred.
// Throughput: one item per cycle while results are taken; the single slot
// memory port serves either the write or the read of that one item.
// Outside reset the input is ready whenever the result register is empty or being drained.
// Reset clears the write pointer and all reader state, sets the ring size to
// 1024 (capped at the ring depth); slot contents stay undefined until written.
// ----------------------------------------------------------------------------
// Broadcast ring top level
// One writer stores entries in a wrapping ring; up to READER_SLOTS readers
// register, sync to the writer and then step through the entries.
// ----------------------------------------------------------------------------
module multi_reader_broadcast_ring
    import mrbr_pkg::*;
#(
    parameter int RING_DEPTH   = 1024,
    parameter int READER_SLOTS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mrbr_in_if.sink           i_in,
    mrbr_out_if.source        o_out,
    mrbr_cfg_if.sink          i_cfg
);

    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int ES_W   = $clog2(RING_DEPTH + 1);
    localparam int CW     = (ES_W > QSIZE_W) ? ES_W : QSIZE_W;
    localparam int RSEL_W = (READER_SLOTS > 1) ? $clog2(READER_SLOTS) : 1;
    localparam logic [CW-1:0] DEPTH_C   = CW'(RING_DEPTH);
    localparam logic [CW-1:0] MIN_SIZE  = CW'(2);
    localparam logic [CW-1:0] RESET_EFF = (RING_DEPTH < 1024) ? CW'(RING_DEPTH) : CW'(1024);

    // Next ring slot, wrapping at the active size.
    function automatic logic [IDX_W-1:0] f_next_slot(
        input logic [IDX_W-1:0] cur,
        input logic [CW-1:0]    lim
    );
        logic [CW-1:0] nxt;
        nxt = CW'(cur) + CW'(1);
        f_next_slot = (nxt >= lim) ? '0 : IDX_W'(nxt);
    endfunction

    // State registers.
    logic [CW-1:0]    r_eff_size;
    logic [IDX_W-1:0] r_last_slot;
    logic             r_any_written;
    logic             r_reg  [READER_SLOTS];
    logic             r_sync [READER_SLOTS];
    logic [IDX_W-1:0] r_pos  [READER_SLOTS];

    // Result register.
    logic              r_out_valid;
    t_status           r_status;
    logic [SLOT_W-1:0] r_slot_index;
    logic              r_more;
    logic              r_known;
    logic              r_started;
    logic              r_has_data;
    t_slot             r_mem_q;

    // Slot memory.
    t_slot             mem [RING_DEPTH];

    logic              in_xfer;
    logic              rid_ok;
    logic [RSEL_W-1:0] rid_sel;
    logic              cur_reg;
    logic              cur_sync;
    logic [IDX_W-1:0]  cur_pos;
    logic [IDX_W-1:0]  pos_next;
    logic [IDX_W-1:0]  wr_slot;
    logic [CW-1:0]     cfg_ext;
    logic [CW-1:0]     cfg_eff;
    logic              do_write;
    logic              do_sync;
    logic              do_fetch;
    logic              do_register;
    t_status           n_status;
    logic [SLOT_W-1:0] n_slot_index;
    logic              n_more;
    logic              n_known;
    logic              n_started;

    // Handshakes; nothing is taken while reset is held.
    assign i_cfg.ready = i_rst_n;
    assign i_in.ready  = i_rst_n && (!r_out_valid || o_out.ready);
    assign in_xfer     = i_in.valid && i_in.ready;

    // Clamp a written ring size into the supported range.
    assign cfg_ext = CW'(i_cfg.data);
    assign cfg_eff = (cfg_ext < MIN_SIZE) ? MIN_SIZE :
                     (cfg_ext > DEPTH_C)  ? DEPTH_C  : cfg_ext;

    // Addressed reader lookup.
    assign rid_ok   = 32'(i_in.data.reader_id) < READER_SLOTS;
    assign rid_sel  = RSEL_W'(i_in.data.reader_id);
    assign cur_reg  = rid_ok && r_reg[rid_sel];
    assign cur_sync = r_sync[rid_sel];
    assign cur_pos  = r_pos[rid_sel];
    assign pos_next = f_next_slot(cur_pos, r_eff_size);
    assign wr_slot  = r_any_written ? f_next_slot(r_last_slot, r_eff_size) : '0;

    // Decode the operation and build the result fields.
    always_comb begin
        do_write     = 1'b0;
        do_sync      = 1'b0;
        do_fetch     = 1'b0;
        do_register  = 1'b0;
        n_status     = ST_DONE;
        n_slot_index = '0;
        n_more       = 1'b0;
        unique case (i_in.data.op)
            OP_WRITE: begin
                do_write     = 1'b1;
                n_slot_index = SLOT_W'(wr_slot);
            end
            OP_REGISTER: begin
                do_register = rid_ok;
            end
            OP_READ: begin
                priority if (!r_any_written) begin
                    n_status = ST_NO_DATA;
                end else if (!cur_reg) begin
                    n_status = ST_UNKNOWN;
                end else if (!cur_sync) begin
                    do_sync  = 1'b1;
                    n_status = ST_NO_DATA;
                end else if (cur_pos == r_last_slot) begin
                    n_status = ST_NO_DATA;
                end else begin
                    do_fetch     = 1'b1;
                    n_status     = ST_NEW_DATA;
                    n_slot_index = SLOT_W'(pos_next);
                    n_more       = pos_next != r_last_slot;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
        // Reader flags as they stand after the operation.
        n_known   = cur_reg || do_register;
        n_started = cur_reg && !do_register && (cur_sync || do_sync);
    end

    // Ring size, write pointer and reader state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_size    <= RESET_EFF;
            r_last_slot   <= '0;
            r_any_written <= 1'b0;
            for (int i = 0; i < READER_SLOTS; i++) begin
                r_reg[i]  <= 1'b0;
                r_sync[i] <= 1'b0;
                r_pos[i]  <= '0;
            end
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_eff_size <= cfg_eff;
            end
            if (in_xfer && do_write) begin
                r_last_slot   <= wr_slot;
                r_any_written <= 1'b1;
            end
            if (in_xfer && do_register) begin
                r_reg[rid_sel]  <= 1'b1;
                r_sync[rid_sel] <= 1'b0;
                r_pos[rid_sel]  <= '0;
            end
            if (in_xfer && do_sync) begin
                r_sync[rid_sel] <= 1'b1;
                r_pos[rid_sel]  <= r_last_slot;
            end
            if (in_xfer && do_fetch) begin
                r_pos[rid_sel] <= pos_next;
            end
        end
    end

    // Slot memory: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (in_xfer && do_write) begin
            mem[wr_slot] <= '{data: i_in.data.entry_data, size: i_in.data.entry_size};
        end
        if (in_xfer && do_fetch) begin
            r_mem_q <= mem[pos_next];
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload, loaded on each input transfer.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_status     <= n_status;
            r_slot_index <= n_slot_index;
            r_more       <= n_more;
            r_known      <= n_known;
            r_started    <= n_started;
            r_has_data   <= do_fetch;
        end
    end

    // Result channel; data and size read as zero unless an entry was fetched.
    assign o_out.valid               = r_out_valid;
    assign o_out.data.status         = r_status;
    assign o_out.data.entry_data_res = r_has_data ? r_mem_q.data : '0;
    assign o_out.data.entry_size_res = r_has_data ? r_mem_q.size : '0;
    assign o_out.data.slot_index     = r_slot_index;
    assign o_out.data.more_data      = r_more;
    assign o_out.data.reader_known   = r_known;
    assign o_out.data.reader_started = r_started;

    // A transfer in always leaves a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_out.valid)
        else $error("result missing after input transfer");

    // New data only goes to a reader that is known and started.
    a_new_data_reader: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.status == ST_NEW_DATA
            |-> o_out.data.reader_known && o_out.data.reader_started)
        else $error("new data for a reader that is not started");

    // The lag flag is only raised along with new data.
    a_more_only_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.more_data |-> o_out.data.status == ST_NEW_DATA)
        else $error("more_data without new data");

    // A write transfer always reports done.
    a_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in.data.op == OP_WRITE |=> o_out.data.status == ST_DONE)
        else $error("write did not report done");

endmodule
